/* rtl/track_quality_monitor_assert.svh */
`ifndef TRACK_QUALITY_MONITOR_ASSERT_SVH
`define TRACK_QUALITY_MONITOR_ASSERT_SVH

// Condition that must hold on every clock edge outside reset.
`define TQM_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define TQM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/tqm_pkg.sv */
package tqm_pkg;

  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 26;

  localparam logic [15:0] Q_ONE        = 16'd32768;
  localparam logic [6:0]  HIST_LEN_RST = 7'd50;
  localparam logic [15:0] STAB_THR_RST = 16'd19661;
  localparam logic [6:0]  QUAL_WIN_RST = 7'd10;

  // 3*S for the quality sum, stable and not stable, plus rounding term
  localparam logic [18:0] QS_HI  = 19'd98304;
  localparam logic [18:0] QS_LO  = 19'd49152;
  localparam logic [18:0] QS_RND = 19'd5;

  // floor(v/10) = (v * RECIP10) >> RECIP_SH, exact for v < 699050
  localparam logic [19:0] RECIP10  = 20'd419431;
  localparam int          RECIP_SH = 22;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_HIST_LEN = 2'd0,
    CFG_STAB_THR = 2'd1,
    CFG_QUAL_WIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_GATE_DX, S_GATE_DY, S_GATE_MM, S_AREA_P, S_AREA_N,
    S_GATE_END, S_PUSH, S_DIV_RATE, S_WALK_INIT, S_WALK, S_STAB, S_DEN1,
    S_DEN2, S_NUM1, S_NUM2, S_NUM3, S_DIV_TREND, S_LAST, S_QSUM, S_QFIN, S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/tqm_div.sv */
module tqm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tqm_pkg::DIV_NW-1:0]   dividend,
  input  logic [tqm_pkg::DIV_DW-1:0]   divisor,
  output tqm_pkg::div_stat_t           stat,
  output logic [tqm_pkg::DIV_NW-1:0]   quotient
);
  import tqm_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;

  // restoring step: one quotient bit per cycle, MSB first
  assign rem_sh  = {rem, quotient[DIV_NW-1]};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      quotient <= {quotient[DIV_NW-2:0], ~rem_sub[DIV_DW]};
      rem      <= rem_sub[DIV_DW] ? rem_sh[DIV_DW-1:0] : rem_sub[DIV_DW-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

/* rtl/track_quality_monitor.sv */
// Divisions run on the serial divider: the area rate on an update once two entries are held
//   and the prior area is nonzero, the trend when n >= 2, n = min(quality_window, entries).
// Words are taken one at a time, in the idle state; the shared multiplier, the serial divider
//   and the single read port of the confidence ring set the rate. The next word is taken while
//   a finished result still waits in the output register.
// Reset (rst, synchronous): registers back to 50 / 19661 / 10, track cleared, no result.
`include "track_quality_monitor_assert.svh"

module track_quality_monitor #(
  parameter int HIST_DEPTH = 64,
  parameter int COORD_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [15:0]                  cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic signed [COORD_BITS-1:0] box_x,
  input  logic signed [COORD_BITS-1:0] box_y,
  input  logic [11:0]                  box_width,
  input  logic [11:0]                  box_height,
  input  logic [15:0]                  confidence,
  // result words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         active,
  output logic [15:0]                  stored_confidence,
  output logic                         transition_ok,
  output logic signed [15:0]           velocity_x_half,
  output logic signed [15:0]           velocity_y_half,
  output logic signed [31:0]           scale_rate,
  output logic                         stable,
  output logic signed [16:0]           trend,
  output logic [15:0]                  quality,
  output logic [6:0]                   entries_held,
  output logic [31:0]                  frame_count
);
  import tqm_pkg::*;

  localparam int IDX_W = $clog2(HIST_DEPTH);
  localparam int AW    = ((IDX_W > 7) ? IDX_W : 7) + 1;
  // doubled centre coordinates: 2*x + w
  localparam int DW    = ((COORD_BITS + 1 > 12) ? COORD_BITS + 1 : 12) + 2;

  state_t state, state_next;

  // configuration registers
  logic [6:0]  hist_len;
  logic [15:0] stab_thr;
  logic [6:0]  qwin;

  // track state
  logic [IDX_W-1:0]             ring_head;
  logic [6:0]                   ring_count;
  logic signed [COORD_BITS-1:0] pbx, pby;
  logic [11:0]                  pbw, pbh;
  logic                         track_on;
  logic [31:0]                  frames_seen;

  // confidence ring (one write, one registered read port)
  logic [15:0]      ring [HIST_DEPTH];
  logic [15:0]      rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  // latched input word
  func_t                        func_q;
  logic signed [COORD_BITS-1:0] bx_q, by_q;
  logic [11:0]                  bw_q, bh_q;
  logic [15:0]                  conf_q;

  // gate
  logic signed [PROD_W-1:0] dsq, mm2;
  logic [23:0]              pa, na;
  logic [15:0]              conf_val;
  logic                     is_upd;
  logic signed [15:0]       vx_c, vy_c;
  logic                     rate_neg;

  // window walk
  logic [6:0]       n_win;
  logic [6:0]       rd_i;
  logic [IDX_W-1:0] raddr;
  logic             dv1, dv2;
  logic [6:0]       x1;
  logic [13:0]      xsq;
  logic [22:0]      sys;
  logic [12:0]      sxs;
  logic [19:0]      sxx;
  logic [28:0]      sxy;
  logic [DIV_DW-1:0]        den;
  logic signed [PROD_W-1:0] t1;
  logic                     trend_neg;

  // result under construction
  logic [15:0]        r_stored;
  logic               r_ok;
  logic signed [15:0] r_vx, r_vy;
  logic signed [31:0] r_srate;
  logic               r_stable;
  logic signed [16:0] r_trend;
  logic [15:0]        r_quality;

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  // shared divider
  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic [DIV_NW-1:0] div_q;
  div_stat_t         div_stat;

  // combinational helpers
  logic signed [DW-1:0]     dx, dy;
  logic [11:0]              mm;
  logic [6:0]               lim, cnt_after, n_now;
  logic [IDX_W-1:0]         head_inc, raddr_inc, last_addr, start_addr;
  logic [AW-1:0]            hs;
  logic                     rd_issue;
  logic [23:0]              na_now;
  logic                     pass;
  logic [24:0]              adiff;
  logic signed [PROD_W-1:0] num, num_mag;
  logic [15:0]              tp16;
  logic [18:0]              qsum;
  logic [PROD_W-RECIP_SH-1:0] qv;
  logic [DIV_NW-1:0]        tq;
  logic                     out_load;

  function automatic logic [6:0] eff_len(input logic [6:0] hl);
    logic [6:0] r;
    if (hl == 7'd0) r = 7'd1;
    else if (AW'(hl) > AW'(HIST_DEPTH)) r = 7'(HIST_DEPTH);
    else r = hl;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [DW-1:0] v);
    logic signed [15:0] r;
    if (int'(v) > 32767) r = 16'sh7FFF;
    else if (int'(v) < -32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  tqm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign in_ready = (state == S_IDLE);

  // centre shift in half pixels, against the prior box
  assign dx = ((DW'(bx_q) <<< 1) + DW'(bw_q)) - ((DW'(pbx) <<< 1) + DW'(pbw));
  assign dy = ((DW'(by_q) <<< 1) + DW'(bh_q)) - ((DW'(pby) <<< 1) + DW'(pbh));
  assign mm = (pbw > pbh) ? pbw : pbh;

  assign lim       = eff_len(hist_len);
  assign cnt_after = (ring_count < lim) ? ring_count + 7'd1 : lim;
  assign n_now     = (qwin < ring_count) ? qwin : ring_count;
  assign head_inc  = (ring_head == IDX_W'(HIST_DEPTH - 1)) ? '0 : ring_head + 1'b1;
  assign raddr_inc = (raddr == IDX_W'(HIST_DEPTH - 1)) ? '0 : raddr + 1'b1;
  assign last_addr = (ring_head == '0) ? IDX_W'(HIST_DEPTH - 1) : ring_head - 1'b1;

  // oldest window entry: head - n, wrapped
  always_comb begin
    hs = AW'(ring_head) + AW'(HIST_DEPTH) - AW'(n_now);
    if (hs >= AW'(HIST_DEPTH)) hs = hs - AW'(HIST_DEPTH);
    start_addr = IDX_W'(hs);
  end

  assign rd_issue = (state == S_WALK) && (rd_i < n_win);

  // gate: motion within half the larger side, area ratio within [0.5, 2]
  assign na_now = 24'(prod);
  assign pass   = !(dsq > mm2) &&
                  !((pa != 24'd0) && (({na_now, 1'b0} < {1'b0, pa}) ||
                                      ({1'b0, na_now} > {pa, 1'b0})));

  assign adiff   = (na >= pa) ? {1'b0, na - pa} : {1'b0, pa - na};
  assign num     = t1 - prod;
  assign num_mag = num[PROD_W-1] ? -num : num;

  assign tp16 = r_trend[16] ? 16'd0 : r_trend[15:0];
  assign qsum = (19'(rd_data) << 2) + 19'(rd_data) + (r_stable ? QS_HI : QS_LO) +
                (19'(tp16) << 1) + QS_RND;
  assign qv   = prod[PROD_W-1:RECIP_SH];
  assign tq   = (div_q > DIV_NW'(Q_ONE)) ? DIV_NW'(Q_ONE) : div_q;

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    rd_en        = 1'b0;
    rd_addr      = raddr;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (func_q) inside
          FUNC_START:             state_next = S_PUSH;
          FUNC_UPDATE:            state_next = track_on ? S_GATE_DX : S_WALK_INIT;
          FUNC_CLEAR, FUNC_NOP:   state_next = S_WALK_INIT;
        endcase
      end
      S_GATE_DX: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
        state_next = S_GATE_DY;
      end
      S_GATE_DY: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
        state_next = S_GATE_MM;
      end
      S_GATE_MM: begin
        mul_a = MUL_W'(mm);
        mul_b = MUL_W'(mm);
        state_next = S_AREA_P;
      end
      S_AREA_P: begin
        mul_a = MUL_W'(pbw);
        mul_b = MUL_W'(pbh);
        state_next = S_AREA_N;
      end
      S_AREA_N: begin
        mul_a = MUL_W'(bw_q);
        mul_b = MUL_W'(bh_q);
        state_next = S_GATE_END;
      end
      S_GATE_END: state_next = S_PUSH;
      S_PUSH: begin
        div_dividend = DIV_NW'(adiff) << 16;
        div_divisor  = DIV_DW'(pa);
        if (is_upd && cnt_after >= 7'd2 && pa != 24'd0) begin
          div_start  = 1'b1;
          state_next = S_DIV_RATE;
        end else begin
          state_next = S_WALK_INIT;
        end
      end
      S_DIV_RATE: if (div_stat.done) state_next = S_WALK_INIT;
      S_WALK_INIT: state_next = S_WALK;
      S_WALK: begin
        rd_en = rd_issue;
        if (dv1) begin
          mul_a = MUL_W'(x1);
          mul_b = MUL_W'(rd_data);
        end
        if (!rd_issue && !dv1 && !dv2) state_next = S_STAB;
      end
      S_STAB: begin
        mul_a = MUL_W'(stab_thr);
        mul_b = MUL_W'(n_win);
        state_next = S_DEN1;
      end
      S_DEN1: begin
        mul_a = MUL_W'(n_win);
        mul_b = MUL_W'(sxx);
        state_next = S_DEN2;
      end
      S_DEN2: begin
        mul_a = MUL_W'(sxs);
        mul_b = MUL_W'(sxs);
        state_next = S_NUM1;
      end
      S_NUM1: begin
        mul_a = MUL_W'(n_win);
        mul_b = MUL_W'(sxy);
        state_next = S_NUM2;
      end
      S_NUM2: begin
        mul_a = MUL_W'(sxs);
        mul_b = MUL_W'(sys);
        state_next = S_NUM3;
      end
      S_NUM3: begin
        div_dividend = (DIV_NW'(num_mag) << 3) + (DIV_NW'(num_mag) << 1);
        div_divisor  = den;
        if (n_win >= 7'd2 && den != '0) begin
          div_start  = 1'b1;
          state_next = S_DIV_TREND;
        end else begin
          state_next = S_LAST;
        end
      end
      S_DIV_TREND: if (div_stat.done) state_next = S_LAST;
      S_LAST: begin
        rd_en      = 1'b1;
        rd_addr    = last_addr;
        state_next = S_QSUM;
      end
      S_QSUM: begin
        mul_a = MUL_W'(qsum);
        mul_b = MUL_W'(RECIP10);
        state_next = S_QFIN;
      end
      S_QFIN: state_next = S_OUT;
      S_OUT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH) ring[ring_head] <= conf_val;
    if (rd_en) rd_data <= ring[rd_addr];
  end

  // track state, configuration and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len    <= HIST_LEN_RST;
      stab_thr    <= STAB_THR_RST;
      qwin        <= QUAL_WIN_RST;
      ring_head   <= '0;
      ring_count  <= '0;
      pbx         <= '0;
      pby         <= '0;
      pbw         <= '0;
      pbh         <= '0;
      track_on    <= 1'b0;
      frames_seen <= '0;
      dv1         <= 1'b0;
      dv2         <= 1'b0;
    end else begin
      dv1 <= rd_issue;
      dv2 <= dv1;

      if (cfg_write) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_HIST_LEN: begin
            hist_len <= cfg_data[6:0];
            // shrinking drops the oldest entries
            if (ring_count > eff_len(cfg_data[6:0])) ring_count <= eff_len(cfg_data[6:0]);
          end
          CFG_STAB_THR: stab_thr <= cfg_data;
          CFG_QUAL_WIN: qwin <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q    <= func_t'(func);
            bx_q      <= box_x;
            by_q      <= box_y;
            bw_q      <= box_width;
            bh_q      <= box_height;
            conf_q    <= (confidence > Q_ONE) ? Q_ONE : confidence;
            is_upd    <= 1'b0;
            r_stored  <= '0;
            r_ok      <= 1'b0;
            r_vx      <= '0;
            r_vy      <= '0;
            r_srate   <= '0;
            r_stable  <= 1'b0;
            r_trend   <= '0;
            r_quality <= '0;
          end
        end
        S_DECODE: begin
          case (func_q)
            FUNC_START: begin
              ring_head   <= '0;
              ring_count  <= '0;
              track_on    <= 1'b1;
              frames_seen <= 32'd1;
              r_stored    <= Q_ONE;
              r_ok        <= 1'b1;
              conf_val    <= Q_ONE;
              pbx         <= bx_q;
              pby         <= by_q;
              pbw         <= bw_q;
              pbh         <= bh_q;
            end
            FUNC_CLEAR: begin
              ring_head   <= '0;
              ring_count  <= '0;
              track_on    <= 1'b0;
              frames_seen <= '0;
              pbx         <= '0;
              pby         <= '0;
              pbw         <= '0;
              pbh         <= '0;
            end
            default: ;
          endcase
        end
        S_GATE_DY: dsq <= prod;
        S_GATE_MM: dsq <= dsq + prod;
        S_AREA_P:  mm2 <= prod;
        S_AREA_N:  pa  <= 24'(prod);
        S_GATE_END: begin
          na       <= na_now;
          conf_val <= pass ? conf_q : (conf_q >> 1);
          r_stored <= pass ? conf_q : (conf_q >> 1);
          r_ok     <= pass;
          is_upd   <= 1'b1;
          vx_c     <= sat16(dx);
          vy_c     <= sat16(dy);
          if (frames_seen != 32'hFFFF_FFFF) frames_seen <= frames_seen + 32'd1;
          pbx      <= bx_q;
          pby      <= by_q;
          pbw      <= bw_q;
          pbh      <= bh_q;
        end
        S_PUSH: begin
          ring_head  <= head_inc;
          ring_count <= cnt_after;
          rate_neg   <= (na < pa);
          if (is_upd && cnt_after >= 7'd2) begin
            r_vx <= vx_c;
            r_vy <= vy_c;
          end
        end
        S_DIV_RATE: begin
          if (div_stat.done) begin
            if (rate_neg) r_srate <= 32'd0 - 32'(div_q);
            else if (div_q > DIV_NW'(32'h7FFF_FFFF)) r_srate <= 32'sh7FFF_FFFF;
            else r_srate <= 32'(div_q);
          end
        end
        S_WALK_INIT: begin
          n_win <= n_now;
          raddr <= start_addr;
          rd_i  <= '0;
          sys   <= '0;
          sxs   <= '0;
          sxx   <= '0;
          sxy   <= '0;
          xsq   <= '0;
        end
        S_WALK: begin
          if (rd_issue) begin
            raddr <= raddr_inc;
            rd_i  <= rd_i + 7'd1;
            x1    <= rd_i;
          end
          if (dv1) begin
            sys <= sys + 23'(rd_data);
            sxs <= sxs + 13'(x1);
            sxx <= sxx + 20'(xsq);
            xsq <= xsq + (14'(x1) << 1) + 14'd1;
          end
          if (dv2) sxy <= sxy + 29'(prod);
        end
        S_DEN1: begin
          r_stable <= track_on && (ring_count >= 7'd3) && (n_win != 7'd0) &&
                      (PROD_W'(sys) >= unsigned'(prod));
        end
        S_DEN2: t1 <= prod;
        S_NUM1: den <= DIV_DW'(t1 - prod);
        S_NUM2: t1 <= prod;
        S_NUM3: trend_neg <= num[PROD_W-1];
        S_DIV_TREND: begin
          if (div_stat.done) r_trend <= trend_neg ? 17'd0 - 17'(tq) : 17'(tq);
        end
        S_QFIN: begin
          if (track_on && ring_count != 7'd0) begin
            r_quality <= (qv > (PROD_W - RECIP_SH)'(Q_ONE)) ? Q_ONE : 16'(qv);
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      active            <= track_on;
      stored_confidence <= r_stored;
      transition_ok     <= r_ok;
      velocity_x_half   <= r_vx;
      velocity_y_half   <= r_vy;
      scale_rate        <= r_srate;
      stable            <= r_stable;
      trend             <= r_trend;
      quality           <= r_quality;
      entries_held      <= ring_count;
      frame_count       <= frames_seen;
    end
  end

  `TQM_ASSERT_HOLDS(a_count_lim, ring_count <= lim, "ring count above history limit")
  `TQM_ASSERT_IMPL(a_div_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `TQM_ASSERT_IMPL(a_idle_word, out_valid && !active, entries_held == 7'd0 && quality == 16'd0, "idle word carries history")
  `TQM_ASSERT_IMPL(a_stable_act, out_valid && stable, active && entries_held >= 7'd3, "stable without enough history")

endmodule

/* bench/tb_track_quality_monitor.sv */
module tb_track_quality_monitor;
  import tqm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 64;
  localparam int EXP_DEPTH = 4096;

  // expected result word, one per accepted input word
  typedef struct {
    logic        active;
    logic [15:0] stored;
    logic        ok;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [31:0] srate;
    logic        stable;
    logic [16:0] trend;
    logic [15:0] quality;
    logic [6:0]  held;
    logic [31:0] frames;
  } track_figures_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic signed [12:0] box_x = '0;
  logic signed [12:0] box_y = '0;
  logic [11:0] box_width = '0;
  logic [11:0] box_height = '0;
  logic [15:0] confidence = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        active;
  logic [15:0] stored_confidence;
  logic        transition_ok;
  logic signed [15:0] velocity_x_half;
  logic signed [15:0] velocity_y_half;
  logic signed [31:0] scale_rate;
  logic        stable;
  logic signed [16:0] trend;
  logic [15:0] quality;
  logic [6:0]  entries_held;
  logic [31:0] frame_count;

  track_quality_monitor dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the block's registers and track state
  logic [6:0]  hist_len_q;
  logic [15:0] stab_thr_q;
  logic [6:0]  qual_win_q;
  logic [15:0] conf_hist [DEPTH];
  int          hist_head;
  int          hist_count;
  longint      prev_x, prev_y, prev_w, prev_h;
  bit          tracking;
  logic [31:0] frames_q;

  // expected words in order: written at input accept, read at result accept
  track_figures_t expected_figures [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;

  bit idle_on = 1'b1;     // random gaps on both sides; off for the tail of the run
  int errors = 0;
  int words_sent = 0;
  int gate_fails = 0;
  int results_seen = 0;

  function automatic int hist_limit();
    if (hist_len_q == 0) return 1;
    if (hist_len_q > DEPTH) return DEPTH;
    return hist_len_q;
  endfunction

  function automatic longint hist_back(int k);
    return conf_hist[(hist_head + DEPTH - 1 - k) % DEPTH];
  endfunction

  function automatic void drop_track();
    for (int i = 0; i < DEPTH; i++) conf_hist[i] = '0;
    hist_head = 0;
    hist_count = 0;
    prev_x = 0; prev_y = 0; prev_w = 0; prev_h = 0;
    tracking = 0;
    frames_q = '0;
  endfunction

  function automatic void push_conf(longint c);
    conf_hist[hist_head] = c[15:0];
    hist_head = (hist_head + 1) % DEPTH;
    if (hist_count < hist_limit()) hist_count++;
    if (hist_count > hist_limit()) hist_count = hist_limit();
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Advance the shadow state by one word and return the figures it yields.
  function automatic track_figures_t track_step(func_t f, longint bx, longint by,
                                                longint bw, longint bh, longint conf);
    track_figures_t r;
    longint pcx, pcy, dx, dy, mm, pa, na, vx, vy, sr, tr, q, sum, n;
    longint sxs, sys, sxy, sxx, num, den, y, s, tp;
    bit pass, st;
    vx = 0; vy = 0; sr = 0; tr = 0; q = 0; st = 0;
    r.stored = '0;
    r.ok = 1'b0;
    if (conf > 32768) conf = 32768;
    if (f == FUNC_START) begin
      drop_track();
      push_conf(32768);
      tracking = 1;
      frames_q = 1;
      r.stored = Q_ONE;
      r.ok = 1'b1;
      prev_x = bx; prev_y = by; prev_w = bw; prev_h = bh;
    end else if (f == FUNC_UPDATE && tracking) begin
      pcx = 2 * prev_x + prev_w;
      pcy = 2 * prev_y + prev_h;
      dx = (2 * bx + bw) - pcx;
      dy = (2 * by + bh) - pcy;
      mm = prev_w > prev_h ? prev_w : prev_h;
      pa = prev_w * prev_h;
      na = bw * bh;
      pass = 1;
      if (dx * dx + dy * dy > mm * mm) pass = 0;
      if (pa > 0 && (2 * na < pa || na > 2 * pa)) pass = 0;
      if (!pass) begin
        conf = conf >> 1;
        gate_fails++;
      end
      push_conf(conf);
      r.stored = conf[15:0];
      r.ok = pass;
      if (hist_count >= 2) begin
        vx = clip(dx, -32768, 32767);
        vy = clip(dy, -32768, 32767);
        if (pa > 0) sr = clip(((na - pa) * 65536) / pa, -longint'(2147483647) - 1,
                              2147483647);
      end
      if (frames_q != 32'hFFFF_FFFF) frames_q++;
      prev_x = bx; prev_y = by; prev_w = bw; prev_h = bh;
    end else if (f == FUNC_CLEAR) begin
      drop_track();
    end

    n = qual_win_q < hist_count ? qual_win_q : hist_count;
    if (tracking && hist_count >= 3 && n > 0) begin
      sum = 0;
      for (int i = 0; i < n; i++) sum += hist_back(i);
      if (sum >= longint'(stab_thr_q) * n) st = 1;
    end
    // least-squares slope over the window, oldest entry at x = 0
    if (hist_count >= 2 && n >= 2) begin
      sxs = 0; sys = 0; sxy = 0; sxx = 0;
      for (int i = 0; i < n; i++) begin
        y = hist_back(n - 1 - i);
        sxs += i; sys += y; sxy += i * y; sxx += i * i;
      end
      den = n * sxx - sxs * sxs;
      num = n * sxy - sxs * sys;
      if (den > 0) tr = clip((num * 10) / den, -32768, 32768);
    end
    if (tracking && hist_count > 0) begin
      s = st ? 32768 : 16384;
      tp = tr > 0 ? tr : 0;
      q = (5 * hist_back(0) + 3 * s + 2 * tp + 5) / 10;
      if (q > 32768) q = 32768;
    end

    r.active = tracking;
    r.vx = vx[15:0];
    r.vy = vy[15:0];
    r.srate = sr[31:0];
    r.stable = st;
    r.trend = tr[16:0];
    r.quality = q[15:0];
    r.held = hist_count[6:0];
    r.frames = frames_q;
    return r;
  endfunction

  // Wait out a random idle burst, if idling is on.
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
  endtask

  // Present one input word and hold it until the block takes it.
  task automatic send_word(func_t f, logic [12:0] bx, logic [12:0] by,
                           logic [11:0] bw, logic [11:0] bh, logic [15:0] conf);
    @(negedge clk);
    in_valid   <= 1'b1;
    func       <= f;
    box_x      <= bx;
    box_y      <= by;
    box_width  <= bw;
    box_height <= bh;
    confidence <= conf;
    do @(posedge clk); while (!in_ready);
    expected_figures[exp_wr % EXP_DEPTH] = track_step(f, longint'($signed(bx)),
                                                      longint'($signed(by)), bw, bh, conf);
    exp_wr++;
    words_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    maybe_idle();
  endtask

  task automatic wait_drained();
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write, only with the block idle.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    wait_drained();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_HIST_LEN: begin
        hist_len_q = value[6:0];
        if (hist_count > hist_limit()) hist_count = hist_limit();
      end
      CFG_STAB_THR: stab_thr_q = value;
      CFG_QUAL_WIN: qual_win_q = value[6:0];
      default: ;
    endcase
  endtask

  // Random word biased toward well-formed track sequences.
  task automatic send_random_word();
    int pick;
    longint nx, ny, nw, nh;
    logic [15:0] c;
    pick = $urandom_range(0, 99);
    c = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
    if (!tracking && pick < 85) pick = 0;
    if (pick < 6) begin
      send_word(FUNC_START, 13'($urandom_range(0, 2000)), 13'($urandom_range(0, 2000)),
                12'($urandom_range(4, 400)), 12'($urandom_range(4, 400)), c);
    end else if (pick < 80) begin
      // small drift and mild resize: mostly passes the gate
      nx = clip(prev_x + $urandom_range(0, 20) - 10, -4096, 4095);
      ny = clip(prev_y + $urandom_range(0, 20) - 10, -4096, 4095);
      nw = clip(prev_w + $urandom_range(0, 16) - 8, 1, 4095);
      nh = clip(prev_h + $urandom_range(0, 16) - 8, 1, 4095);
      if ($urandom_range(0, 9) == 0) nw = clip(prev_w * 3, 0, 4095);
      if ($urandom_range(0, 9) == 0) nx = clip(prev_x + prev_w * 2 + 1, -4096, 4095);
      send_word(FUNC_UPDATE, 13'(nx), 13'(ny), 12'(nw), 12'(nh), c);
    end else if (pick < 84) begin
      send_word(FUNC_CLEAR, 13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom), c);
    end else if (pick < 88) begin
      send_word(FUNC_NOP, 13'($urandom), 13'($urandom), 12'($urandom), 12'($urandom), c);
    end else begin
      send_word(func_t'($urandom_range(0, 3)), 13'($urandom), 13'($urandom),
                12'($urandom), 12'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    // update before any track: ignored
    send_word(FUNC_UPDATE, 13'd10, 13'd10, 12'd20, 12'd20, 16'd30000);
    send_word(FUNC_START, 13'h1000, 13'h0FFF, 12'd0, 12'd0, 16'hFFFF);
    // zero previous area: no scale rate
    send_word(FUNC_UPDATE, 13'h0FFF, 13'h1000, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_word(FUNC_UPDATE, 13'h0FFF, 13'h1000, 12'hFFF, 12'hFFF, 16'd32768);
    send_word(FUNC_UPDATE, 13'h1000, 13'h0FFF, 12'd1, 12'd1, 16'd0);
    send_word(FUNC_UPDATE, 13'h1000, 13'h0FFF, 12'd2, 12'd1, 16'd1);
    send_word(FUNC_UPDATE, 13'h1000, 13'h0FFF, 12'd2, 12'd2, 16'd32767);
    send_word(FUNC_NOP, 13'h1555, 13'h0AAA, 12'hAAA, 12'h555, 16'hAAAA);
    // restart while active
    send_word(FUNC_START, 13'd100, 13'd100, 12'd50, 12'd50, 16'd0);
    for (int i = 0; i < 6; i++)
      send_word(FUNC_UPDATE, 13'(100 + i), 13'd100, 12'd50, 12'd50, 16'(32768 - i * 4000));
    send_word(FUNC_UPDATE, 13'd100, 13'd100, 12'd25, 12'd50, 16'd20000);
    send_word(FUNC_UPDATE, 13'd100, 13'd100, 12'd24, 12'd25, 16'd20000);
    send_word(FUNC_CLEAR, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0);
    send_word(FUNC_UPDATE, 13'd1, 13'd1, 12'd1, 12'd1, 16'd1);
    send_word(FUNC_NOP, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0);
  endtask

  task automatic test_register_sweep();
    logic [15:0] hl [6] = '{16'd1, 16'd64, 16'd0, 16'd127, 16'd3, 16'hFF80};
    logic [15:0] th [6] = '{16'd0, 16'd32768, 16'hFFFF, 16'd19661, 16'd16384, 16'd1};
    logic [15:0] qw [6] = '{16'd0, 16'd1, 16'd64, 16'd127, 16'd2, 16'd10};
    for (int k = 0; k < 6; k++) begin
      write_reg(CFG_HIST_LEN, hl[k]);
      write_reg(CFG_STAB_THR, th[k]);
      write_reg(CFG_QUAL_WIN, qw[k]);
      send_word(FUNC_START, 13'd0, 13'd0, 12'd40, 12'd40, 16'd0);
      repeat (70) send_random_word();
      // shrink the history mid-track
      write_reg(CFG_HIST_LEN, 16'd2);
      repeat (10) send_random_word();
    end
    write_reg(CFG_HIST_LEN, 16'(HIST_LEN_RST));
    write_reg(CFG_STAB_THR, STAB_THR_RST);
    write_reg(CFG_QUAL_WIN, 16'(QUAL_WIN_RST));
  endtask

  task automatic test_random_tracks();
    repeat (900) send_random_word();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (200) send_random_word();
  endtask

  // result side: random stalls in bursts
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // check every accepted result against the oldest expectation
  always @(posedge clk) begin
    track_figures_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (exp_rd == exp_wr) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected_figures[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (active !== e.active) begin
          $error("active: expected %0d got %0d", e.active, active); errors++;
        end
        if (stored_confidence !== e.stored) begin
          $error("stored_confidence: expected %0d got %0d", e.stored, stored_confidence);
          errors++;
        end
        if (transition_ok !== e.ok) begin
          $error("transition_ok: expected %0d got %0d", e.ok, transition_ok); errors++;
        end
        if (velocity_x_half !== e.vx) begin
          $error("velocity_x_half: expected %0d got %0d", $signed(e.vx), velocity_x_half);
          errors++;
        end
        if (velocity_y_half !== e.vy) begin
          $error("velocity_y_half: expected %0d got %0d", $signed(e.vy), velocity_y_half);
          errors++;
        end
        if (scale_rate !== e.srate) begin
          $error("scale_rate: expected %0d got %0d", $signed(e.srate), scale_rate); errors++;
        end
        if (stable !== e.stable) begin
          $error("stable: expected %0d got %0d", e.stable, stable); errors++;
        end
        if (trend !== e.trend) begin
          $error("trend: expected %0d got %0d", $signed(e.trend), trend); errors++;
        end
        if (quality !== e.quality) begin
          $error("quality: expected %0d got %0d", e.quality, quality); errors++;
        end
        if (entries_held !== e.held) begin
          $error("entries_held: expected %0d got %0d", e.held, entries_held); errors++;
        end
        if (frame_count !== e.frames) begin
          $error("frame_count: expected %0d got %0d", e.frames, frame_count); errors++;
        end
      end
    end
  end

  initial begin
    hist_len_q = HIST_LEN_RST;
    stab_thr_q = STAB_THR_RST;
    qual_win_q = QUAL_WIN_RST;
    drop_track();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_sweep();
    test_random_tracks();
    test_back_to_back();
    wait_drained();
    repeat (300) @(negedge clk);
    if (exp_wr != exp_rd) begin
      $error("%0d results never arrived", exp_wr - exp_rd);
      errors++;
    end
    $display("Sent %0d words (%0d failed the gate), checked %0d results,",
             words_sent, gate_fails, results_seen);
    $display("across six register settings including zero and out-of-range lengths.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
